@@ design/bfsp_pkg.sv @@
// Shared types and constants for the BFS pull-relaxation engine.
// Holds store geometry, request function codes, result kinds and the
// controller/datapath command and status structs. No dependencies.
package bfsp_pkg;

	localparam int NODE_BITS   = 16;
	localparam int DIST_BITS   = 16;
	localparam int STORE_DEPTH = 1 << NODE_BITS;

	localparam logic [DIST_BITS-1:0] UNREACHED = {DIST_BITS{1'b1}};
	localparam logic [DIST_BITS-1:0] DIST_ZERO = '0;

	typedef enum logic [1:0] {
		FUNC_INIT  = 2'd0,
		FUNC_RELAX = 2'd1,
		FUNC_READ  = 2'd2
	} func_t;

	localparam logic KIND_RELAX = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic needs_out;
		logic out_blocked;
	} dp_status_t;

endpackage

@@ design/bfs_pull_relax_engine.sv @@
// Top level of the BFS pull-relaxation engine.
// Joins bfsp_ctrl and bfsp_datapath; depends on bfsp_pkg.
//
// Requests enter on the input channel (in_valid, in_stall) with func, node,
// neighbour and last_edge. Results leave on the output channel (out_valid,
// out_stall) with kind, node_out, distance and improved. Init requests and
// relax requests that are not the last edge of a run give no result.
// The source node register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce it.
// A request is captured first, and both distances are read from the two
// read ports of the distance memory; then its result is computed, written
// back and loaded into the output register. No new request is taken until
// the current one commits.
// When the receiver stalls, the result stays in the output register and
// the block still accepts one more request; that request holds in its
// execute cycle only if it has a result of its own to deliver.
// Reset clears the controller, the output valid, the running minimum and
// the source register. The distance memory is not cleared and must be
// initialized by init requests before it is read.
module bfs_pull_relax_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [15:0] node,
	input  logic [15:0] neighbour,
	input  logic        last_edge,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [15:0] node_out,
	output logic [15:0] distance,
	output logic        improved,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import bfsp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	bfsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bfsp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.func      (func),
		.node      (node),
		.neighbour (neighbour),
		.last_edge (last_edge),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.node_out  (node_out),
		.distance  (distance),
		.improved  (improved)
	);

endmodule

@@ design/bfsp_ctrl.sv @@
// Controller state machine of the BFS pull-relaxation engine.
// Sequences request capture and commit; depends on bfsp_pkg.
module bfsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bfsp_pkg::dp_status_t status,
	output bfsp_pkg::dp_cmd_t    cmd
);
	import bfsp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!status.needs_out || !status.out_blocked) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/bfsp_datapath.sv @@
// Datapath of the BFS pull-relaxation engine: distance memory, request
// registers, running minimum, source register and output register.
// Depends on bfsp_pkg.
module bfsp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfsp_pkg::dp_cmd_t    cmd,
	output bfsp_pkg::dp_status_t status,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic [1:0]           func,
	input  logic [15:0]          node,
	input  logic [15:0]          neighbour,
	input  logic                 last_edge,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 kind,
	output logic [15:0]          node_out,
	output logic [15:0]          distance,
	output logic                 improved
);
	import bfsp_pkg::*;

	logic [DIST_BITS-1:0] mem [STORE_DEPTH];

	logic [DIST_BITS-1:0] nb_dist_s1;
	logic [DIST_BITS-1:0] node_dist_s1;
	logic [1:0]           func_q;
	logic [15:0]          node_q;
	logic                 last_q;
	logic [15:0]          source_q;
	logic [DIST_BITS-1:0] run_min_q;
	logic                 out_valid_q;
	logic                 kind_q;
	logic [15:0]          node_out_q;
	logic [15:0]          distance_q;
	logic                 improved_q;

	logic [DIST_BITS-1:0] cand;
	logic [DIST_BITS-1:0] new_min;
	logic                 better;
	logic                 wr_en;
	logic [DIST_BITS-1:0] wr_data;
	logic                 is_init;
	logic                 is_relax;
	logic                 is_read;
	logic                 has_result;
	logic [DIST_BITS-1:0] res_dist;
	logic [NODE_BITS-1:0] wr_addr;

	assign is_init  = (func_q == FUNC_INIT);
	assign is_relax = (func_q == FUNC_RELAX);
	assign is_read  = (func_q == FUNC_READ);

	assign cand    = (nb_dist_s1 == UNREACHED) ? UNREACHED : nb_dist_s1 + DIST_BITS'(1);
	assign new_min = (cand < run_min_q) ? cand : run_min_q;
	assign better  = node_dist_s1 > new_min;

	assign has_result = (is_relax && last_q) || is_read;
	assign wr_en      = is_init || (is_relax && last_q && better);
	assign wr_data    = is_init ? ((node_q == source_q) ? DIST_ZERO : UNREACHED) : new_min;
	assign wr_addr    = node_q[NODE_BITS-1:0];
	assign res_dist   = (is_relax && better) ? new_min : node_dist_s1;

	assign status.needs_out   = has_result;
	assign status.out_blocked = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.load) begin
			nb_dist_s1   <= mem[neighbour[NODE_BITS-1:0]];
			node_dist_s1 <= mem[node[NODE_BITS-1:0]];
			func_q       <= func;
			node_q       <= node;
			last_q       <= last_edge;
		end
		if (cmd.commit && has_result) begin
			kind_q     <= is_read ? KIND_READ : KIND_RELAX;
			node_out_q <= node_q;
			distance_q <= 16'(res_dist);
			improved_q <= is_relax && better;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q    <= '0;
			run_min_q   <= UNREACHED;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				source_q <= cfg_wdata;
			end
			if (cmd.commit && is_relax) begin
				run_min_q <= last_q ? UNREACHED : new_min;
			end
			if (cmd.commit && has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign node_out  = node_out_q;
	assign distance  = distance_q;
	assign improved  = improved_q;

endmodule

@@ sim/bfs_pull_relax_engine_tb.sv @@
// Self-checking testbench for bfs_pull_relax_engine, built on bfsp_pkg.
// Sends init, relax and read requests with random idling on the input and
// output stalls, and checks every result against a distance predictor here.
`timescale 1ns / 100ps

module bfs_pull_relax_engine_tb;
	import bfsp_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RESET_CYCLES = 12;
	localparam int PHASE_REQS = 80;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] node;
		logic [15:0] nbr;
		logic        last;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] node;
		logic [15:0] dist_val;
		logic        improved;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = FUNC_INIT;
	logic [15:0] node = '0;
	logic [15:0] neighbour = '0;
	logic        last_edge = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [15:0] node_out;
	logic [15:0] distance;
	logic        improved;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	req_t pending_reqs[$];
	res_t due_results[$];
	logic [15:0] known_nodes[$];
	req_t next_req;

	logic [DIST_BITS-1:0] dist_shadow [STORE_DEPTH];
	logic [DIST_BITS-1:0] min_shadow = UNREACHED;
	logic                 run_open = 1'b0;
	logic [15:0]          src_shadow = '0;

	int  bad_results = 0;
	int  cycle_count = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_req = 0;
	int  hold_seen = 0;
	bit  calm = 1'b0;

	bfs_pull_relax_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.node      (node),
		.neighbour (neighbour),
		.last_edge (last_edge),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.node_out  (node_out),
		.distance  (distance),
		.improved  (improved),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] pick_known();
		return known_nodes[$urandom_range(0, known_nodes.size() - 1)];
	endfunction

	function automatic logic [15:0] fresh_node();
		if ($urandom_range(0, 1))
			return 16'($urandom_range(0, 31));
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic push_req(logic [1:0] f, logic [15:0] n, logic [15:0] nb, logic l);
		req_t r;
		r.func = f;
		r.node = n;
		r.nbr = nb;
		r.last = l;
		pending_reqs.push_back(r);
		if (f == FUNC_INIT)
			known_nodes.push_back(n);
	endtask

	task automatic update_distances(req_t r);
		logic [DIST_BITS-1:0] cand;
		logic [DIST_BITS-1:0] cur;
		res_t res;
		case (r.func)
			FUNC_INIT: begin
				dist_shadow[r.node] = (r.node == src_shadow) ? DIST_ZERO : UNREACHED;
			end
			FUNC_RELAX: begin
				cand = dist_shadow[r.nbr];
				if (cand != UNREACHED)
					cand = cand + 1'b1;
				if (cand < min_shadow)
					min_shadow = cand;
				if (!r.last) begin
					run_open = 1'b1;
				end else begin
					cur = dist_shadow[r.node];
					res.improved = cur > min_shadow;
					if (res.improved) begin
						cur = min_shadow;
						dist_shadow[r.node] = cur;
					end
					min_shadow = UNREACHED;
					run_open = 1'b0;
					res.kind = KIND_RELAX;
					res.node = r.node;
					res.dist_val = cur;
					due_results.push_back(res);
				end
			end
			FUNC_READ: begin
				res.kind = KIND_READ;
				res.node = r.node;
				res.dist_val = dist_shadow[r.node];
				res.improved = 1'b0;
				due_results.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			bad_results++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (due_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual kind %b node %h dist %h imp %b",
				$time, kind, node_out, distance, improved);
			bad_results++;
		end else begin
			want = due_results.pop_front();
			check_field("kind", 16'(want.kind), 16'(kind));
			check_field("node_out", want.node, node_out);
			check_field("distance", want.dist_val, distance);
			check_field("improved", 16'(want.improved), 16'(improved));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_INIT;
			node <= '0;
			neighbour <= '0;
			last_edge <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				update_distances(req_t'{func, node, neighbour, last_edge});
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					func <= next_req.func;
					node <= next_req.node;
					neighbour <= next_req.nbr;
					last_edge <= next_req.last;
					in_valid <= 1'b1;
					gap_left <= idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_seen <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				stall_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				int w;
				w = idle_len();
				out_stall <= (w != 0);
				stall_left <= (w != 0) ? w - 1 : 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic run_phase(logic [15:0] src, bit with_directed, bit quiet, bit long_hold);
		int count;
		int sel;
		int len;
		logic [15:0] target;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= src;
		@(posedge clk);
		cfg_we <= 1'b0;
		src_shadow = src;
		@(negedge clk);
		calm = quiet;
		push_req(FUNC_INIT, src, src, 1'b0);
		if (with_directed) begin
			push_req(FUNC_INIT, 16'hFFFF, 16'h0000, 1'b1);
			push_req(FUNC_INIT, 16'h00FF, 16'h0000, 1'b0);
			push_req(FUNC_INIT, 16'hA5A5, 16'hFFFF, 1'b0);
			push_req(FUNC_READ, 16'h0000, 16'hFFFF, 1'b1);
			push_req(FUNC_READ, 16'hFFFF, 16'h0000, 1'b0);
			push_req(FUNC_RELAX, 16'hFFFF, 16'h0000, 1'b1);
			push_req(FUNC_RELAX, 16'h00FF, 16'hFFFF, 1'b0);
			push_req(FUNC_RELAX, 16'h00FF, 16'h0000, 1'b0);
			push_req(FUNC_RELAX, 16'h00FF, 16'hA5A5, 1'b1);
			push_req(FUNC_RELAX, 16'h0000, 16'hFFFF, 1'b1);
			push_req(FUNC_RELAX, 16'hA5A5, 16'hA5A5, 1'b1);
			push_req(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
			push_req(FUNC_RELAX, 16'hA5A5, 16'h00FF, 1'b0);
			push_req(FUNC_READ, 16'h00FF, 16'h0000, 1'b0);
			push_req(FUNC_INIT, 16'h1234, 16'h0000, 1'b0);
			push_req(FUNC_RELAX, 16'hA5A5, 16'h0000, 1'b1);
			push_req(FUNC_READ, 16'hA5A5, 16'h00FF, 1'b0);
			push_req(FUNC_INIT, 16'hFFFF, 16'h0000, 1'b0);
			push_req(FUNC_READ, 16'hFFFF, 16'h1234, 1'b0);
			push_req(FUNC_RELAX, 16'h1234, 16'hFFFF, 1'b1);
			push_req(FUNC_READ, 16'h1234, 16'hA5A5, 1'b1);
		end
		count = 0;
		repeat (8) begin
			push_req(FUNC_INIT, fresh_node(), pick_known(), rand_bit());
			count++;
		end
		while (count < PHASE_REQS) begin
			sel = $urandom_range(0, 99);
			target = pick_known();
			if (sel < 50) begin
				len = $urandom_range(1, 4);
				for (int k = 1; k <= len; k++)
					push_req(FUNC_RELAX, target, pick_known(), k == len);
				count += len;
			end else if (sel < 65) begin
				push_req(FUNC_READ, target, pick_known(), rand_bit());
				count++;
			end else if (sel < 75) begin
				push_req(FUNC_INIT, rand_bit() ? target : fresh_node(),
					pick_known(), rand_bit());
				count++;
			end else if (sel < 85) begin
				push_req(FUNC_RELAX, pick_known(), pick_known(), 1'b0);
				if (sel < 80)
					push_req(FUNC_READ, pick_known(), pick_known(), rand_bit());
				else
					push_req(FUNC_INIT, fresh_node(), pick_known(), rand_bit());
				push_req(FUNC_RELAX, target, pick_known(), 1'b1);
				count += 3;
			end else if (sel < 92) begin
				push_req(FUNC_UNUSED, target, pick_known(), rand_bit());
			end else begin
				push_req(FUNC_RELAX, target, pick_known(), 1'b0);
				count++;
			end
		end
		if (long_hold)
			hold_req++;
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		run_phase(16'h0000, 1'b1, 1'b0, 1'b0);
		run_phase(16'hFFFF, 1'b0, 1'b0, 1'b1);
		run_phase(16'($urandom_range(0, 65535)), 1'b0, 1'b1, 1'b0);
		run_phase(pick_known(), 1'b0, 1'b0, 1'b0);
		run_phase(pick_known(), 1'b0, 1'b0, 1'b0);
		if (bad_results == 0 && due_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
